### src/dtfd_pkg.sv
// ----------------------------------------------------------------------------
// DShot telemetry frame decoder package
// Shared types and constants for the telemetry word decoder.
// ----------------------------------------------------------------------------
package dtfd_pkg;

   // Field widths
   localparam int MOTOR_W   = 3;
   localparam int WORD_W    = 12;
   localparam int TYPE_W    = 3;
   localparam int VALUE_W   = 20;
   localparam int MASK_W    = 8;
   localparam int TEMP_W    = 8;
   localparam int PERIOD_W  = 16;
   localparam int MANT_W    = 9;
   localparam int EXP_W     = 3;

   // Serial divider: one quotient bit per step
   localparam int DIV_STEPS = VALUE_W;
   localparam int DIV_CNT_W = 5;

   // Decoding constants
   localparam logic [VALUE_W-1:0] ERPM_SCALE       = 20'd600000;
   localparam logic [WORD_W-1:0]  WORD_ZERO_RPM    = 12'hFFF;
   localparam logic [MASK_W-1:0]  EXT_TYPE_MASK    = 8'hFE;
   localparam logic [TYPE_W-1:0]  TYPE_ERPM        = 3'd0;
   localparam logic [TYPE_W-1:0]  TYPE_TEMPERATURE = 3'd1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // Divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Update request toward the per-motor store
   typedef struct packed {
      logic              commit;
      logic              apply;
      logic [TYPE_W-1:0] ftype;
      logic [TEMP_W-1:0] data;
   } store_req_type;

   // Current and updated per-motor values from the store
   typedef struct packed {
      logic [MASK_W-1:0] cur_mask;
      logic [MASK_W-1:0] new_mask;
      logic [TEMP_W-1:0] new_temp;
   } store_view_type;

endpackage

### src/dtfd_divider.sv
// ----------------------------------------------------------------------------
// DShot telemetry serial divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtfd_divider
   import dtfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VALUE_W-1:0]  numerator,
   input  logic [PERIOD_W-1:0] divisor,
   output logic [VALUE_W-1:0]  quotient,
   output div_status_type      status
);

   logic [PERIOD_W-1:0]  rem_ff, rem_in;
   logic [VALUE_W-1:0]   quo_ff, quo_in;
   logic [PERIOD_W-1:0]  div_ff, div_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [PERIOD_W:0]    trial;
   logic [PERIOD_W+1:0]  diff;
   logic                 fits;

   // One step: bring down the next numerator bit and try a subtraction.
   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_W-1]};
      diff  = {1'b0, trial} - {2'b00, div_ff};
      fits  = ~diff[PERIOD_W+1];

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         quo_in  = numerator;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
         quo_in = {quo_ff[VALUE_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath shift registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### src/dtfd_store.sv
// ----------------------------------------------------------------------------
// DShot telemetry per-motor store
// Seen-type masks and peak temperatures for each motor.
// ----------------------------------------------------------------------------
module dtfd_store
   import dtfd_pkg::*;
#(
   parameter int MOTORS = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [MOTOR_W-1:0] motor,
   input  store_req_type      req,
   output store_view_type     view
);

   // Only motors that the index field can name get storage.
   localparam int SLOTS = (MOTORS < 8) ? MOTORS : 8;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   logic [MASK_W-1:0] mask_ff [SLOTS];
   logic [MASK_W-1:0] mask_in [SLOTS];
   logic [TEMP_W-1:0] temp_ff [SLOTS];
   logic [TEMP_W-1:0] temp_in [SLOTS];

   logic              have;
   logic [IDX_W-1:0]  idx;
   logic [MASK_W-1:0] cur_mask;
   logic [TEMP_W-1:0] cur_temp;
   logic [MASK_W-1:0] upd_mask;
   logic [TEMP_W-1:0] upd_temp;

   // Read the addressed motor and work out its updated values.
   always_comb begin
      have     = 32'(motor) < 32'(MOTORS);
      idx      = motor[IDX_W-1:0];
      cur_mask = have ? mask_ff[idx] : '0;
      cur_temp = have ? temp_ff[idx] : '0;
      upd_mask = cur_mask;
      upd_temp = cur_temp;
      if (have && req.apply) begin
         upd_mask = cur_mask | (MASK_W'(1) << req.ftype);
         if (req.ftype == TYPE_TEMPERATURE && req.data > cur_temp) begin
            upd_temp = req.data;
         end
      end
      view.cur_mask = cur_mask;
      view.new_mask = upd_mask;
      view.new_temp = upd_temp;
   end

   // Write back the addressed entry on commit.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         mask_in[i] = mask_ff[i];
         temp_in[i] = temp_ff[i];
         if (req.commit && have && idx == IDX_W'(i)) begin
            mask_in[i] = upd_mask;
            temp_in[i] = upd_temp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            mask_ff[i] <= '0;
            temp_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            mask_ff[i] <= mask_in[i];
            temp_ff[i] <= temp_in[i];
         end
      end
   end

endmodule

### src/dshot_telemetry_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// DShot telemetry frame decoder
// Classifies GCR-decoded telemetry words as eRPM or extended frames.
// ----------------------------------------------------------------------------
// The block takes one telemetry word at a time and returns exactly one result
// for it. An eRPM word is converted to eRPM/100 by a serial divider that
// produces one quotient bit per cycle; such a word passes through the
// accepting cycle, the decode cycle, the divider steps, the cycle that picks
// up the quotient and the write-back cycle; extended frames, the all-ones
// word and zero periods skip the divider. The finished result sits in an
// output register, so the next word is taken while the previous result
// waits; that next word then holds in its write-back cycle until the
// receiver takes the waiting result.
// Per-motor seen-type masks and peak temperatures live in flip-flops that
// reset clears at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module dshot_telemetry_frame_decoder_top
   import dtfd_pkg::*;
#(
   parameter int MOTORS = 8
)
(
   input  logic        clock,
   input  logic        reset,

   // Configuration
   input  logic        csr_wen,
   input  logic        csr_wdata,     // force_extended

   // Telemetry words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // motor_index[2:0], raw_frame[14:3]

   // Decoded results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // decoded_value[19:0], seen_types[27:20],
                                      // peak_temperature[35:28]
   output logic [3:0]  rsp_tuser      // frame_type[2:0], value_invalid[3]
);

   state_type state_ff, state_in;

   logic               force_ff, force_in;
   logic [MOTOR_W-1:0] motor_ff, motor_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [TYPE_W-1:0]  ftype_ff, ftype_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               invalid_ff, invalid_in;

   logic               out_valid_ff, out_valid_in;
   logic [TYPE_W-1:0]  out_type_ff, out_type_in;
   logic [VALUE_W-1:0] out_value_ff, out_value_in;
   logic               out_invalid_ff, out_invalid_in;
   logic [MASK_W-1:0]  out_mask_ff, out_mask_in;
   logic [TEMP_W-1:0]  out_temp_ff, out_temp_in;

   logic [3:0]          nibble;
   logic                ext_on;
   logic                is_ext;
   logic [MANT_W-1:0]   mant;
   logic [EXP_W-1:0]    expo;
   logic [PERIOD_W-1:0] period;
   logic [VALUE_W-1:0]  numerator;
   logic                out_free;
   logic                div_start;
   logic [VALUE_W-1:0]  quotient;
   div_status_type      div_status;
   store_req_type       store_req;
   store_view_type      store_view;

   // Word classification
   always_comb begin
      nibble    = word_ff[WORD_W-1:WORD_W-4];
      ext_on    = force_ff | (|(store_view.cur_mask & EXT_TYPE_MASK));
      is_ext    = ext_on && !nibble[0] && nibble != 4'd0;
      mant      = word_ff[MANT_W-1:0];
      expo      = word_ff[WORD_W-1:MANT_W];
      period    = PERIOD_W'(mant) << expo;
      numerator = ERPM_SCALE + VALUE_W'(period >> 1);
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      motor_in   = motor_ff;
      word_in    = word_ff;
      ftype_in   = ftype_ff;
      value_in   = value_ff;
      invalid_in = invalid_ff;
      div_start  = 1'b0;
      req_tready = 1'b0;
      out_free   = !out_valid_ff || rsp_tready;

      store_req.commit = 1'b0;
      store_req.apply  = !invalid_ff;
      store_req.ftype  = ftype_ff;
      store_req.data   = value_ff[TEMP_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               motor_in = req_tdata[MOTOR_W-1:0];
               word_in  = req_tdata[MOTOR_W+WORD_W-1:MOTOR_W];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            invalid_in = 1'b0;
            if (is_ext) begin
               ftype_in = nibble[3:1];
               value_in = VALUE_W'(word_ff[7:0]);
               state_in = ST_DONE;
            end else if (word_ff == WORD_ZERO_RPM) begin
               ftype_in = TYPE_ERPM;
               value_in = '0;
               state_in = ST_DONE;
            end else if (mant == '0) begin
               ftype_in   = TYPE_ERPM;
               value_in   = '0;
               invalid_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               ftype_in  = TYPE_ERPM;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               value_in = quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               store_req.commit = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: loaded when the result is committed.
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_type_in    = out_type_ff;
      out_value_in   = out_value_ff;
      out_invalid_in = out_invalid_ff;
      out_mask_in    = out_mask_ff;
      out_temp_in    = out_temp_ff;
      if (store_req.commit) begin
         out_valid_in   = 1'b1;
         out_type_in    = invalid_ff ? TYPE_ERPM : ftype_ff;
         out_value_in   = invalid_ff ? '0 : value_ff;
         out_invalid_in = invalid_ff;
         out_mask_in    = store_view.new_mask;
         out_temp_in    = store_view.new_temp;
      end
   end

   // Configuration register
   assign force_in = csr_wen ? csr_wdata : force_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         force_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         force_ff     <= force_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      motor_ff       <= motor_in;
      word_ff        <= word_in;
      ftype_ff       <= ftype_in;
      value_ff       <= value_in;
      invalid_ff     <= invalid_in;
      out_type_ff    <= out_type_in;
      out_value_ff   <= out_value_in;
      out_invalid_ff <= out_invalid_in;
      out_mask_ff    <= out_mask_in;
      out_temp_ff    <= out_temp_in;
   end

   dtfd_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (numerator),
      .divisor   (period),
      .quotient  (quotient),
      .status    (div_status)
   );

   dtfd_store #(
      .MOTORS (MOTORS)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .motor (motor_ff),
      .req   (store_req),
      .view  (store_view)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_temp_ff, out_mask_ff, out_value_ff};
   assign rsp_tuser  = {out_invalid_ff, out_type_ff};

endmodule

### src/dtfd_checker.sv
// ----------------------------------------------------------------------------
// DShot telemetry decoder checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module dtfd_checker
   import dtfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The block works on one word at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word taken while one is in work");

   // An invalid period reports type eRPM and a zero value.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == TYPE_ERPM && rsp_tdata[19:0] == '0)
      else $error("invalid result carries data");

   // eRPM/100 never exceeds the scale constant, and padding stays clear.
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:0] <= ERPM_SCALE && rsp_tdata[39:36] == 4'b0000)
      else $error("decoded value out of range");

endmodule

bind dshot_telemetry_frame_decoder_top dtfd_checker u_dtfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_dshot_telemetry_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// DShot telemetry frame decoder testbench
// Drives telemetry words under both settings of the force-extended register
// and checks every decoded result against an in-bench decoder that tracks
// the per-motor seen-type masks and peak temperatures.
// ----------------------------------------------------------------------------
module tb_dshot_telemetry_frame_decoder_top;
   import dtfd_pkg::*;

   localparam int MOTORS        = 8;
   localparam int SILENCE_LIMIT = 3000;
   localparam int DRAIN_CYCLES  = 30;
   localparam int STALL_CYCLES  = 400;
   localparam int STALL_AT      = 600;

   // Telemetry kinds as carried in the upper nibble of an extended frame.
   typedef enum logic [TYPE_W-1:0] {
      KIND_ERPM, KIND_TEMP, KIND_VOLTAGE, KIND_CURRENT,
      KIND_DEBUG1, KIND_DEBUG2, KIND_DEBUG3, KIND_EVENTS
   } telemetry_kind_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  ftype;
      logic [VALUE_W-1:0] value;
      logic               invalid;
      logic [MASK_W-1:0]  seen;
      logic [TEMP_W-1:0]  peak;
   } decoded_frame_type;

   // Decoder predictor with its own per-motor state and queue of pending frames.
   class telemetry_scoreboard;
      bit                force_ext;
      logic [MASK_W-1:0] seen_mask [MOTORS];
      logic [TEMP_W-1:0] peak_temp [MOTORS];
      decoded_frame_type pending_frames [$];
      int                failures;

      function new();
         force_ext = 1'b0;
         failures  = 0;
         foreach (seen_mask[i]) begin
            seen_mask[i] = '0;
            peak_temp[i] = '0;
         end
      endfunction

      function int pending();
         return pending_frames.size();
      endfunction

      // Decode one accepted word, update the motor's state and queue the result.
      function void note_word(logic [MOTOR_W-1:0] motor, logic [WORD_W-1:0] word);
         decoded_frame_type frame;
         bit                known;
         bit                ext_on;
         bit                valid;
         logic [3:0]        nib;
         logic [MASK_W-1:0] mask;
         logic [TYPE_W-1:0] kind;
         int unsigned       period;
         int unsigned       rate;
         known  = int'(motor) < MOTORS;
         mask   = known ? seen_mask[motor] : '0;
         nib    = word[11:8];
         ext_on = force_ext || ((mask & EXT_TYPE_MASK) != '0);
         rate   = 0;
         if (ext_on && !nib[0] && nib != 4'd0) begin
            kind  = nib[3:1];
            rate  = {24'd0, word[7:0]};
            valid = 1'b1;
         end else begin
            kind = TYPE_ERPM;
            if (word == WORD_ZERO_RPM) begin
               valid = 1'b1;
            end else begin
               period = {23'd0, word[8:0]};
               period = period << word[11:9];
               valid  = period != 0;
               if (valid)
                  rate = (ERPM_SCALE + period / 2) / period;
            end
         end
         if (valid && known) begin
            seen_mask[motor][kind] = 1'b1;
            if (kind == TYPE_TEMPERATURE && rate > peak_temp[motor])
               peak_temp[motor] = rate[TEMP_W-1:0];
         end
         frame.ftype   = valid ? kind : TYPE_ERPM;
         frame.value   = valid ? rate[VALUE_W-1:0] : '0;
         frame.invalid = !valid;
         frame.seen    = known ? seen_mask[motor] : '0;
         frame.peak    = known ? peak_temp[motor] : '0;
         pending_frames.push_back(frame);
      endfunction

      // Compare one result field by field with the oldest pending frame.
      function void check_result(decoded_frame_type got);
         decoded_frame_type want;
         if (pending_frames.size() == 0) begin
            $error("result with no pending frame: value %0d", got.value);
            failures++;
            return;
         end
         want = pending_frames.pop_front();
         if (got.ftype !== want.ftype) begin
            $error("frame_type: expected %0d, got %0d", want.ftype, got.ftype);
            failures++;
         end
         if (got.value !== want.value) begin
            $error("decoded_value: expected %0d, got %0d", want.value, got.value);
            failures++;
         end
         if (got.invalid !== want.invalid) begin
            $error("value_invalid: expected %0d, got %0d", want.invalid, got.invalid);
            failures++;
         end
         if (got.seen !== want.seen) begin
            $error("seen_types: expected %h, got %h", want.seen, got.seen);
            failures++;
         end
         if (got.peak !== want.peak) begin
            $error("peak_temperature: expected %0d, got %0d", want.peak, got.peak);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wen;
   logic        csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;

   telemetry_scoreboard board;
   int req_idle_pct = 37;
   int rsp_idle_pct = 37;
   int results_seen = 0;
   int silent_cycles = 0;
   int stall_left = 0;
   bit stall_done = 1'b0;

   dshot_telemetry_frame_decoder_top #(.MOTORS(MOTORS)) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Build an extended frame word from its kind and data byte.
   function automatic logic [WORD_W-1:0] ext_word(telemetry_kind_type kind, logic [7:0] data);
      return {kind, 1'b0, data};
   endfunction

   // Offer one word, with random gaps, and wait for its transfer.
   task automatic send_word(input logic [MOTOR_W-1:0] motor, input logic [WORD_W-1:0] word);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, word, motor};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_word(motor, word);
      @(negedge clock);
   endtask

   // Random words: mostly well-formed extended frames and periods, some noise.
   task automatic send_random(input int count, input int top_motor);
      int                  pick;
      logic [WORD_W-1:0]   word;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 35)
            word = WORD_W'($urandom_range(4095));
         else if (pick < 65)
            word = ext_word(telemetry_kind_type'($urandom_range(7, 1)), 8'($urandom));
         else if (pick < 75)
            word = {3'($urandom_range(7)), 9'd0};
         else if (pick < 80)
            word = WORD_ZERO_RPM;
         else
            word = {3'($urandom_range(7)), 9'($urandom_range(511, 1))};
         send_word(MOTOR_W'($urandom_range(top_motor)), word);
      end
   endtask

   // Wait until every pending result has arrived and the block has gone idle.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_force(input logic value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      board.force_ext = value;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver: random stalls plus one long hold-off to back up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!stall_done && results_seen >= STALL_AT) begin
         rsp_tready <= 1'b0;
         stall_left = STALL_CYCLES;
         stall_done = 1'b1;
      end else begin
         rsp_tready <= $urandom_range(99) >= rsp_idle_pct;
      end
   end

   // Result monitor and watchdog on transfers.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            board.check_result({rsp_tuser[2:0], rsp_tdata[19:0], rsp_tuser[3],
                                rsp_tdata[27:20], rsp_tdata[35:28]});
            results_seen++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            silent_cycles = 0;
         else
            silent_cycles++;
         if (silent_cycles >= SILENCE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      board      = new();
      reset      = 1'b1;
      csr_wen    = 1'b0;
      csr_wdata  = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Periods only: all-ones word, zero periods, extremes of the period.
      write_force(1'b0);
      send_word(3'd0, WORD_ZERO_RPM);
      send_word(3'd0, 12'h000);
      send_word(3'd1, 12'hE00);
      send_word(3'd2, 12'h001);
      send_word(3'd3, 12'h1FF);
      send_word(3'd4, 12'hFFE);
      send_word(3'd5, 12'h200);
      send_word(3'd6, 12'h201);
      send_word(3'd7, ext_word(KIND_VOLTAGE, 8'hAB));
      send_random(480, MOTORS - 1);
      settle();

      // Forced extended decoding, which covers every motor; words go to motors 0 to 5.
      write_force(1'b1);
      send_word(3'd0, ext_word(KIND_TEMP, 8'hC8));
      send_word(3'd0, ext_word(KIND_TEMP, 8'h50));
      send_word(3'd0, ext_word(KIND_TEMP, 8'hFF));
      send_word(3'd1, ext_word(KIND_VOLTAGE, 8'h00));
      send_word(3'd1, ext_word(KIND_CURRENT, 8'h7F));
      send_word(3'd2, ext_word(KIND_DEBUG1, 8'h01));
      send_word(3'd2, ext_word(KIND_DEBUG2, 8'h80));
      send_word(3'd3, ext_word(KIND_DEBUG3, 8'hFE));
      send_word(3'd3, ext_word(KIND_EVENTS, 8'h00));
      send_word(3'd4, 12'h3FF);
      send_word(3'd4, 12'h000);
      send_word(3'd5, WORD_ZERO_RPM);
      send_word(3'd5, 12'h0FF);
      send_random(480, 5);
      settle();

      // Not forced: motors that saw extended types keep decoding them.
      write_force(1'b0);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random(200, MOTORS - 1);
      req_idle_pct = 37;
      rsp_idle_pct = 37;
      send_random(280, MOTORS - 1);
      settle();

      write_force(1'b1);
      send_random(480, MOTORS - 1);
      settle();

      if (board.failures == 0 && board.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
